[rtl/imu_tcb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tcb_pkg
// Constants and the arctangent table shared by the tilt blend unit and its
// CORDIC engine.
// ----------------------------------------------------------------------------
package imu_tcb_pkg;

    localparam int ANG_W = 26;   // angle width, 2^-16 degree
    localparam int CX_W  = 28;   // CORDIC vector width

    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;

    localparam logic [17:0] GYRO_K     = 18'd251990;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [16:0] WEIGHT_RST = 17'd62259;
    localparam logic [17:0] WEIGHT_ONE = 18'd65536;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [21:0] atan_step(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117266;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/imu_tcb_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tcb_isqrt
// Integer square root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module imu_tcb_isqrt
    import imu_tcb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_val,
    output logic             o_busy,
    output logic [23:0]      o_root
);

    logic        r_busy;
    logic [47:0] r_v, r_res, r_bit;
    logic [47:0] n_v, n_res;
    logic [47:0] trial;

    always_comb begin
        trial = r_res + r_bit;
        if (r_v >= trial) begin
            n_v   = r_v - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_v   = r_v;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= 48'h1 << 46;
        end else if (r_busy) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[23:0];

endmodule
`default_nettype wire

[rtl/imu_tcb_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tcb_cordic
// Vectoring CORDIC atan2(y, x), one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module imu_tcb_cordic
    import imu_tcb_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [CX_W-1:0]  i_x,
    input  wire logic signed [CX_W-1:0]  i_y,
    output logic                         o_busy,
    output logic signed [ANG_W-1:0]      o_z
);

    localparam int CW = $clog2(STEPS);

    logic                    r_busy, r_zero;
    logic [CW-1:0]           r_cnt;
    logic signed [CX_W-1:0]  r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ANG_W-1:0] r_z, n_z, a;

    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        a  = $signed({4'b0, atan_step(5'(r_cnt))});
        if (!r_y[CX_W-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + a;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(STEPS - 1)) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_cnt  <= '0;
            r_zero <= (i_x == '0) && (i_y == '0);
            // fold the left half-plane onto the right one
            if (i_x[CX_W-1]) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= i_y[CX_W-1] ? -DEG180 : DEG180;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_z    = r_zero ? '0 : r_z;

endmodule
`default_nettype wire

[rtl/imu_tilt_complementary_blend_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_complementary_blend_unit
// Roll and pitch from one IMU sample: accelerometer tilt, integrated gyro
// angles and their weighted blend.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per IMU sample (gyro x/y, accel x/y/z, timestamp).
//   Master stream: one beat per sample with six angles in 1/128 degree.
//   Config: i_cfg_wr_en writes the accelerometer blend weight (Q1.16); write
//   it only while no sample is in flight.
//   Timing: the square root (one root bit per cycle) and the pitch CORDIC
//   (one micro-rotation a cycle) run back to back and set the time a sample
//   takes; the roll CORDIC and the bit-serial gyro scaling overlap with the
//   square root. The next beat is taken only after the result is loaded into
//   the output register. One sample is in work at a time.
//   Stall: a result waits in the output register while i_m_axis_tready is
//   low; the unit still accepts and processes the next sample, and holds
//   in its last step until the output register frees up.
//   Reset: the weight returns to 0.95, gyro angles and the stored timestamp
//   clear, and the first sample after reset skips integration.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_blend_unit
    import imu_tcb_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave beat, low bit up: gyro_x[15:0] gyro_y[31:16] accel_x[47:32]
    // accel_y[63:48] accel_z[79:64] time_sec[111:80] time_nsec[141:112]
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [143:0] i_s_axis_tdata,
    // master beat, low bit up: roll_fused[15:0] pitch_fused[31:16]
    // roll_from_gyro[47:32] pitch_from_gyro[63:48] roll_from_accel[79:64]
    // pitch_from_accel[94:80]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [95:0]       o_m_axis_tdata,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [16:0]  i_cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_PREP2, S_SQRT, S_CORP, S_BLR, S_BLP, S_BLF
    } t_state;

    t_state r_state;

    logic [16:0]        r_weight;
    logic               r_first;
    logic [31:0]        r_prev_sec;
    logic [29:0]        r_prev_nsec;
    logic signed [31:0] r_ang_r, r_ang_p;

    logic signed [15:0] r_ax, r_ay, r_az;
    logic [15:0]        r_gmag_r, r_gmag_p;
    logic               r_gneg_r, r_gneg_p;
    logic [31:0]        r_sec;
    logic [29:0]        r_nsec;
    logic [29:0]        r_dt;
    logic [31:0]        r_sq_y, r_sq_z;

    logic [63:0]        r_msh_r, r_msh_p, r_gacc_r, r_gacc_p;
    logic [17:0]        r_kbits;

    logic signed [ANG_W-1:0] r_acc_r, r_acc_p;
    logic signed [43:0]      r_pa;
    logic signed [49:0]      r_pg;
    logic [15:0]             r_fused_r;

    logic               r_ovalid;
    logic [95:0]        r_odata;

    logic                    s_accept;
    logic                    rc_busy, pc_busy, sq_busy;
    logic signed [ANG_W-1:0] rc_z, pc_z;
    logic [23:0]             sq_root;
    logic signed [CX_W-1:0]  rc_x, rc_y, pc_x, pc_y;

    logic signed [32:0] ds;
    logic signed [33:0] dsum;
    logic [29:0]        n_dt;
    logic signed [31:0] n_ang_r, n_ang_p;
    logic signed [ANG_W-1:0] acc_r_cl, acc_p_cl;
    logic signed [17:0] w_s, wc_s;
    logic [15:0]        blend_q;
    logic [15:0]        pacc_out;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)        return 16'h7FFF;
        else if (v < -34'sd32768)  return 16'h8000;
        else                       return v[15:0];
    endfunction

    function automatic logic [15:0] to_out(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd256) >>> 9;
        return sat16(t);
    endfunction

    function automatic logic signed [31:0] integ(input logic signed [31:0] ang,
                                                 input logic [63:0] prod,
                                                 input logic neg);
        logic [63:0]        rnd;
        logic signed [33:0] d, s;
        rnd = prod + (64'h1 << 37);
        d   = $signed({8'b0, rnd[63:38]});
        s   = 34'(ang) + (neg ? -d : d);
        if (s > 34'sd2147483647)        return 32'sh7FFFFFFF;
        else if (s < -34'sd2147483648)  return 32'sh80000000;
        else                            return s[31:0];
    endfunction

    // elapsed time, clamped to 0..1 s; nanoseconds taken as given, so a
    // two-second step can still land inside one second
    always_comb begin
        ds   = $signed({1'b0, r_sec}) - $signed({1'b0, r_prev_sec});
        dsum = $signed({4'b0, r_nsec}) - $signed({4'b0, r_prev_nsec});
        if (ds == 33'sd1)       dsum = dsum + $signed({4'b0, NS_PER_SEC});
        else if (ds == 33'sd2)  dsum = dsum + $signed({4'b0, NS_PER_SEC})
                                            + $signed({4'b0, NS_PER_SEC});
        else if (ds == -33'sd1) dsum = dsum - $signed({4'b0, NS_PER_SEC});
        if (ds > 33'sd2)                             n_dt = NS_PER_SEC;
        else if (ds < -33'sd1 || dsum < 34'sd0)      n_dt = '0;
        else if (dsum > $signed({4'b0, NS_PER_SEC})) n_dt = NS_PER_SEC;
        else                                         n_dt = dsum[29:0];
    end

    always_comb begin
        n_ang_r = integ(r_ang_r, r_gacc_r, r_gneg_r);
        n_ang_p = integ(r_ang_p, r_gacc_p, r_gneg_p);
    end

    always_comb begin
        if (rc_z > DEG180)       acc_r_cl = DEG180;
        else if (rc_z < -DEG180) acc_r_cl = -DEG180;
        else                     acc_r_cl = rc_z;
        if (pc_z > DEG90)        acc_p_cl = DEG90;
        else if (pc_z < -DEG90)  acc_p_cl = -DEG90;
        else                     acc_p_cl = pc_z;
    end

    // w*acc + (1-w)*gyro, round half up at 2^-25, saturate
    always_comb begin
        logic signed [50:0] s;
        w_s     = $signed({1'b0, r_weight});
        wc_s    = $signed(WEIGHT_ONE) - w_s;
        s       = 51'(r_pa) + 51'(r_pg) + 51'sd16777216;
        blend_q = sat16(34'($signed(s[50:25])));
    end

    assign pacc_out = to_out(34'(r_acc_p));

    assign rc_x = CX_W'(r_az) <<< 8;
    assign rc_y = CX_W'(r_ay) <<< 8;
    assign pc_x = $signed({{(CX_W-24){1'b0}}, sq_root});
    assign pc_y = CX_W'(r_ax) <<< 8;

    imu_tcb_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_x     (rc_x),
        .i_y     (rc_y),
        .o_busy  (rc_busy),
        .o_z     (rc_z)
    );

    imu_tcb_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT && !sq_busy),
        .i_x     (pc_x),
        .i_y     (pc_y),
        .o_busy  (pc_busy),
        .o_z     (pc_z)
    );

    imu_tcb_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP2),
        .i_val   ({r_sq_y + r_sq_z, 16'h0}),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_weight    <= WEIGHT_RST;
            r_first     <= 1'b1;
            r_prev_sec  <= '0;
            r_prev_nsec <= '0;
            r_ang_r     <= '0;
            r_ang_p     <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_weight <= i_cfg_wr_data;
            end
            // drop the result once the receiver takes the beat, unless a new
            // one is loaded in the same cycle
            if (r_ovalid && i_m_axis_tready && r_state != S_BLF) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_gmag_r <= i_s_axis_tdata[15] ? -i_s_axis_tdata[15:0]
                                                       : i_s_axis_tdata[15:0];
                        r_gneg_r <= i_s_axis_tdata[15];
                        // pitch rate is the negated gyro y
                        r_gmag_p <= i_s_axis_tdata[31] ? -i_s_axis_tdata[31:16]
                                                       : i_s_axis_tdata[31:16];
                        r_gneg_p <= !i_s_axis_tdata[31] && (i_s_axis_tdata[31:16] != '0);
                        r_ax     <= i_s_axis_tdata[47:32];
                        r_ay     <= i_s_axis_tdata[63:48];
                        r_az     <= i_s_axis_tdata[79:64];
                        r_sec    <= i_s_axis_tdata[111:80];
                        r_nsec   <= i_s_axis_tdata[141:112];
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_dt        <= n_dt;
                    r_prev_sec  <= r_sec;
                    r_prev_nsec <= r_nsec;
                    r_sq_y      <= 32'(r_ay * r_ay);
                    r_sq_z      <= 32'(r_az * r_az);
                    r_state     <= S_PREP2;
                end
                S_PREP2: begin
                    r_msh_r  <= 64'(r_gmag_r * r_dt);
                    r_msh_p  <= 64'(r_gmag_p * r_dt);
                    r_gacc_r <= '0;
                    r_gacc_p <= '0;
                    r_kbits  <= GYRO_K;
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    // advance the bit-serial gyro scaling alongside the root
                    if (r_kbits[0]) begin
                        r_gacc_r <= r_gacc_r + r_msh_r;
                        r_gacc_p <= r_gacc_p + r_msh_p;
                    end
                    r_msh_r <= r_msh_r << 1;
                    r_msh_p <= r_msh_p << 1;
                    r_kbits <= r_kbits >> 1;
                    if (!sq_busy) begin
                        if (r_first) begin
                            r_first <= 1'b0;
                        end else begin
                            r_ang_r <= n_ang_r;
                            r_ang_p <= n_ang_p;
                        end
                        r_state <= S_CORP;
                    end
                end
                S_CORP: begin
                    if (!pc_busy) begin
                        r_acc_r <= acc_r_cl;
                        r_acc_p <= acc_p_cl;
                        r_state <= S_BLR;
                    end
                end
                S_BLR: begin
                    r_pa    <= 44'(w_s * r_acc_r);
                    r_pg    <= 50'(wc_s * r_ang_r);
                    r_state <= S_BLP;
                end
                S_BLP: begin
                    r_fused_r <= blend_q;
                    r_pa      <= 44'(w_s * r_acc_p);
                    r_pg      <= 50'(wc_s * r_ang_p);
                    r_state   <= S_BLF;
                end
                S_BLF: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= {1'b0,
                                     pacc_out[14:0],
                                     to_out(34'(r_acc_r)),
                                     to_out(34'(r_ang_p)),
                                     to_out(34'(r_ang_r)),
                                     blend_q,
                                     r_fused_r};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !rc_busy && !pc_busy && !sq_busy)
        else $error("arithmetic unit busy while idle");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("second sample taken while one is in work");

    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(r_state == S_SQRT))
        else $error("first-sample flag cleared outside integration");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[79:64]) <= 16'sd23040) &&
                            ($signed(o_m_axis_tdata[79:64]) >= -16'sd23040))
        else $error("accelerometer roll out of range");

endmodule
`default_nettype wire

[verif/imu_tilt_complementary_blend_unit_test.sv]
// ----------------------------------------------------------------------------
// imu_tilt_complementary_blend_unit_test
// Self-checking bench for the tilt blend unit: drives IMU sample beats, with
// random gaps outside the directed test, predicts every angle in the testbench,
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_blend_unit_test;
    import imu_tcb_pkg::*;

    localparam int STEPS       = 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 120;
    localparam int CFG_INDEX   = 0;

    typedef struct packed {
        logic [15:0] pitch_acc;
        logic [15:0] roll_acc;
        logic [15:0] pitch_gyr;
        logic [15:0] roll_gyr;
        logic [15:0] pitch_fus;
        logic [15:0] roll_fus;
    } angles_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [95:0]  o_m_axis_tdata;
    logic         i_cfg_wr_en;
    logic [16:0]  i_cfg_wr_data;

    imu_tilt_complementary_blend_unit #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state, mirrors the unit's registers
    logic [16:0]    weight_q;
    bit             first_q;
    logic [31:0]    prev_sec_q;
    logic [29:0]    prev_nsec_q;
    longint         roll_int_q;
    longint         pitch_int_q;

    angles_t        pending_angles[$];
    int             errors;
    int             idle_cycles;
    bit             sink_stall_on;

    // Arctangent step table in 2^-16 degree
    function automatic longint atan_entry(input int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117266,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint clampl(input longint v, input longint lo,
                                      input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_root(input longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // Vectoring rotation, arithmetic shifts floor as required
    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_entry(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic longint integrate_rate(input longint angle,
                                              input longint rate,
                                              input longint dt);
        longint unsigned mag;
        longint delta;
        mag = longint'(rate < 0 ? -rate : rate) * dt;
        delta = longint'((mag * 64'd251990 + (64'd1 << 37)) >> 38);
        if (rate < 0) delta = -delta;
        return clampl(angle + delta, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic [15:0] to_128th(input longint v);
        return 16'(clampl((v + 256) >>> 9, -32768, 32767));
    endfunction

    function automatic logic [15:0] blend_angle(input longint acc, input longint gyr);
        longint w;
        longint s;
        w = longint'(weight_q);
        s = w * acc + (65536 - w) * gyr;
        return 16'(clampl((s + (64'sd1 <<< 24)) >>> 25, -32768, 32767));
    endfunction

    // Work out the six angles for one sample and advance the predictor
    task automatic predict_angles(input logic [143:0] beat);
        longint gx, gy, ax, ay, az, dt, roll_acc, pitch_acc, root;
        angles_t a;
        logic [15:0] pacc;
        gx = longint'($signed(beat[15:0]));
        gy = -longint'($signed(beat[31:16]));
        ax = longint'($signed(beat[47:32]));
        ay = longint'($signed(beat[63:48]));
        az = longint'($signed(beat[79:64]));
        dt = (longint'(beat[111:80]) - longint'(prev_sec_q)) * 1000000000
           + (longint'(beat[141:112]) - longint'(prev_nsec_q));
        dt = clampl(dt, 0, 1000000000);
        prev_sec_q = beat[111:80];
        prev_nsec_q = beat[141:112];
        roll_acc = clampl(vector_angle(ay * 256, az * 256), -11796480, 11796480);
        root = int_root((ay * ay + az * az) <<< 16);
        pitch_acc = clampl(vector_angle(ax * 256, root), -5898240, 5898240);
        if (first_q) begin
            first_q = 1'b0;
        end else begin
            roll_int_q = integrate_rate(roll_int_q, gx, dt);
            pitch_int_q = integrate_rate(pitch_int_q, gy, dt);
        end
        a.roll_fus  = blend_angle(roll_acc, roll_int_q);
        a.pitch_fus = blend_angle(pitch_acc, pitch_int_q);
        a.roll_gyr  = to_128th(roll_int_q);
        a.pitch_gyr = to_128th(pitch_int_q);
        a.roll_acc  = to_128th(roll_acc);
        pacc        = to_128th(pitch_acc);
        a.pitch_acc = {1'b0, pacc[14:0]};
        pending_angles.insert(pending_angles.size(), a);
    endtask

    function automatic int gap_len();
        // Mostly back to back or short, now and then a long pause
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(50, 200);
        return $urandom_range(1, 6);
    endfunction

    // Send one sample beat and hold it until accepted; drop valid only
    // across a gap so back-to-back beats keep it high
    task automatic send_sample(input logic [15:0] gx, input logic [15:0] gy,
                               input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [31:0] sec,
                               input logic [29:0] nsec, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, nsec, sec, az, ay, ax, gy, gx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_angles(i_s_axis_tdata);
    endtask

    // Wait for every result, then let the unit settle before a register write
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [16:0] w);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        if (CFG_INDEX == 0) weight_q = w;
    endtask

    // Directed: field extremes, zero vector, roll flip, time specials
    task automatic test_directed();
        send_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                    32'd5, 30'd0, 1'b0);
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h8000,
                    32'd5, 30'd500000000, 1'b0);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                    32'd9, 30'd0, 1'b0);
        send_sample(16'h1234, 16'hfedc, 16'h0100, 16'h8000, 16'h8000,
                    32'd8, 30'd0, 1'b0);
        send_sample(16'h1000, 16'h1000, 16'h7fff, 16'h0000, 16'h0000,
                    32'd8, 30'h3fffffff, 1'b0);
        send_sample(16'hffff, 16'h0001, 16'h8000, 16'h0001, 16'hffff,
                    32'hffffffff, 30'd999999999, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0980,
                    32'd0, 30'd0, 1'b0);
        send_sample(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'hf680,
                    32'd0, 30'd0, 1'b0);
    endtask

    // Saturate the integrators with a long run of full-scale rates
    task automatic test_saturation();
        logic [31:0] sec;
        sec = 32'd100;
        for (int i = 0; i < 100; i++) begin
            sec = sec + 1;
            send_sample(16'h7fff, 16'h8000, 16'(i * 997), 16'h0200, 16'h0900,
                        sec, 30'd0, 1'b1);
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] sec;
        logic [29:0] nsec;
        logic [31:0] r;
        longint step;
        sec = $urandom;
        nsec = 30'($urandom_range(0, 999999999));
        for (int i = 0; i < count; i++) begin
            // Mostly forward steady timestamps, sometimes jumps or raw noise
            case ($urandom_range(0, 9))
                0: begin
                    sec = $urandom;
                    nsec = 30'($urandom);
                end
                1: sec = sec - $urandom_range(0, 2);
                default: begin
                    step = longint'(nsec) + $urandom_range(0, 20000000);
                    if (step > 999999999) begin
                        sec = sec + 1;
                        step = step - 1000000000;
                    end
                    nsec = 30'(step);
                end
            endcase
            r = $urandom;
            if (r[0]) begin
                send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), sec, nsec, 1'b1);
            end else begin
                send_sample(16'($signed($urandom_range(0, 8000)) - 4000),
                            16'($signed($urandom_range(0, 8000)) - 4000),
                            16'($signed($urandom_range(0, 5000)) - 2500),
                            16'($signed($urandom_range(0, 5000)) - 2500),
                            16'($signed($urandom_range(0, 5000)) - 2500),
                            sec, nsec, 1'b1);
            end
        end
    endtask

    // Result checker: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        angles_t got;
        angles_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = angles_t'(o_m_axis_tdata);
            if (pending_angles.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time,
                         o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_angles.pop_front();
                if (got != want) begin
                    $display("%0t: angles expected %h actual %h", $time,
                             want, got);
                    errors++;
                end
            end
        end
    end

    // Sink stalls: random stretches, sometimes a clean window
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) sink_stall_on <= ~sink_stall_on;
        if (!sink_stall_on) begin
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 29) == 0) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog: abort if no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        sink_stall_on = 1'b0;
        errors = 0;
        idle_cycles = 0;
        weight_q = 17'd62259;
        first_q = 1'b1;
        prev_sec_q = '0;
        prev_nsec_q = '0;
        roll_int_q = 0;
        pitch_int_q = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_random(60);
        write_weight(17'd65536);
        test_random(60);
        write_weight(17'd0);
        test_directed();
        test_random(60);
        write_weight(17'h1ffff);
        test_random(50);
        write_weight(17'($urandom));
        test_random(50);

        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

[files.f]
rtl/imu_tcb_pkg.sv
rtl/imu_tcb_isqrt.sv
rtl/imu_tcb_cordic.sv
rtl/imu_tilt_complementary_blend_unit.sv
verif/imu_tilt_complementary_blend_unit_test.sv
